FILE: rtl/rau_pkg.sv
`default_nettype none
package rau_pkg;

  localparam int MAG_WIDTH_DEF = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        a_negative;
    logic [30:0] a_numerator;
    logic [30:0] a_denominator;
    logic        b_negative;
    logic [30:0] b_numerator;
    logic [30:0] b_denominator;
  } in_item_t;

  typedef struct packed {
    logic        res_negative;
    logic [30:0] res_numerator;
    logic [30:0] res_denominator;
    logic [1:0]  status;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // latch request, check operands
    logic mul;       // form cross products
    logic combine;   // form numerator and denominator
    logic gcd_step;  // setup or one remainder bit of a Euclid step
    logic div_start; // start quotient pass
    logic div_step;  // one quotient bit for num and den
    logic finish;    // form result
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic bad;       // zero denominator or divide by zero
    logic num_zero;
    logic gcd_done;
    logic div_done;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/rau_datapath.sv
`default_nettype none
module rau_datapath
  import rau_pkg::*;
#(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  req,
  input  wire dp_cmd_t   cmd,
  output dp_sts_t        sts,
  output out_item_t      res
);

  localparam int PW = 2 * MAG_WIDTH + 1;
  localparam int CW = $clog2(PW + 1);

  logic [MAG_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic                 asg_r, bsg_r;
  op_t                  op_r;
  logic                 bad_r;
  logic [2*MAG_WIDTH-1:0] p_r, q_r, d_r;
  logic [PW-1:0]        num_r, den_r, x_r, y_r, rem_r;
  logic                 neg_r;
  // Quotient pass: num and den divided by the gcd, shift-subtract over bits
  logic [PW-1:0]        dvs_r, qn_r, qd_r, rn_r, rd_r;
  logic [CW-1:0]        cnt_r;
  logic                 gmode_r, gdone_r;
  out_item_t            res_r;

  logic                 bneg;
  logic [PW-1:0]        rn_sh, rd_sh, g_sh;
  logic                 ovf;

  assign bneg = (op_r == OP_SUB) ? ~bsg_r : bsg_r;
  assign rn_sh = {rn_r[PW-2:0], num_r[PW-1-cnt_r[CW-1:0]]};
  assign rd_sh = {rd_r[PW-2:0], den_r[PW-1-cnt_r[CW-1:0]]};
  assign g_sh  = {rem_r[PW-2:0], x_r[PW-1-cnt_r[CW-1:0]]};
  assign ovf = (qn_r[PW-1:MAG_WIDTH] != '0) || (qd_r[PW-1:MAG_WIDTH] != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gdone_r <= 1'b0;
      gmode_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cmd.load) begin
        op_r  <= op_t'(req.req_type);
        asg_r <= req.a_negative;
        bsg_r <= req.b_negative;
        an_r  <= req.a_numerator[MAG_WIDTH-1:0];
        ad_r  <= req.a_denominator[MAG_WIDTH-1:0];
        bn_r  <= req.b_numerator[MAG_WIDTH-1:0];
        bd_r  <= req.b_denominator[MAG_WIDTH-1:0];
        bad_r <= (req.a_denominator[MAG_WIDTH-1:0] == '0) ||
                 (req.b_denominator[MAG_WIDTH-1:0] == '0) ||
                 ((op_t'(req.req_type) == OP_DIV) &&
                  (req.b_numerator[MAG_WIDTH-1:0] == '0));
      end
      if (cmd.mul) begin
        case (op_r)
          OP_MUL: begin
            p_r <= an_r * bn_r;
            q_r <= '0;
            d_r <= ad_r * bd_r;
          end
          OP_DIV: begin
            p_r <= an_r * bd_r;
            q_r <= '0;
            d_r <= ad_r * bn_r;
          end
          default: begin
            p_r <= an_r * bd_r;
            q_r <= bn_r * ad_r;
            d_r <= ad_r * bd_r;
          end
        endcase
      end
      if (cmd.combine) begin
        den_r <= {1'b0, d_r};
        if (op_r == OP_MUL || op_r == OP_DIV) begin
          num_r <= {1'b0, p_r};
          neg_r <= asg_r ^ bsg_r;
        end else if (asg_r == bneg) begin
          num_r <= {1'b0, p_r} + {1'b0, q_r};
          neg_r <= asg_r;
        end else if (p_r >= q_r) begin
          num_r <= {1'b0, p_r - q_r};
          neg_r <= asg_r;
        end else begin
          num_r <= {1'b0, q_r - p_r};
          neg_r <= bneg;
        end
        gdone_r <= 1'b0;
        gmode_r <= 1'b0;
      end
      // gcd: x mod y by restoring division, one bit a cycle
      if (cmd.gcd_step) begin
        if (!gmode_r) begin
          gmode_r <= 1'b1;
          cnt_r   <= '0;
          rem_r   <= '0;
          if (x_r == '0 && y_r == '0) begin
            x_r <= num_r;
            y_r <= den_r;
          end
        end else begin
          if (g_sh >= y_r) rem_r <= g_sh - y_r;
          else             rem_r <= g_sh;
          if (cnt_r == CW'(PW - 1)) begin
            x_r     <= y_r;
            y_r     <= (g_sh >= y_r) ? g_sh - y_r : g_sh;
            gmode_r <= 1'b0;
            cnt_r   <= '0;
            if (((g_sh >= y_r) ? g_sh - y_r : g_sh) == '0) gdone_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
      end
      if (cmd.combine) begin
        x_r <= '0;
        y_r <= '0;
      end
      if (cmd.div_start) begin
        dvs_r <= x_r;
        qn_r  <= '0;
        qd_r  <= '0;
        rn_r  <= '0;
        rd_r  <= '0;
        cnt_r <= '0;
      end
      if (cmd.div_step) begin
        qn_r  <= {qn_r[PW-2:0], rn_sh >= dvs_r};
        qd_r  <= {qd_r[PW-2:0], rd_sh >= dvs_r};
        rn_r  <= (rn_sh >= dvs_r) ? rn_sh - dvs_r : rn_sh;
        rd_r  <= (rd_sh >= dvs_r) ? rd_sh - dvs_r : rd_sh;
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.finish) begin
        if (bad_r) begin
          res_r <= '{1'b0, 31'd0, 31'd1, ST_DIV_ZERO};
        end else if (num_r == '0) begin
          res_r <= '{1'b0, 31'd0, 31'd1, ST_OK};
        end else if (ovf) begin
          res_r <= '{1'b0, 31'd0, 31'd1, ST_OVERFLOW};
        end else begin
          res_r <= '{neg_r, 31'(qn_r[MAG_WIDTH-1:0]), 31'(qd_r[MAG_WIDTH-1:0]), ST_OK};
        end
      end
    end
  end

  assign sts.bad      = bad_r;
  assign sts.num_zero = (num_r == '0);
  assign sts.gcd_done = gdone_r && !gmode_r;
  assign sts.div_done = (cnt_r == CW'(PW - 1));
  assign res = res_r;

endmodule
`default_nettype wire

FILE: rtl/rau_ctrl.sv
`default_nettype none
module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_COMB, S_CHECK, S_GCD, S_DSTART, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE:   cmd.load      = in_valid;
      S_MUL:    cmd.mul       = 1'b1;
      S_COMB:   cmd.combine   = 1'b1;
      S_GCD:    cmd.gcd_step  = 1'b1;
      S_DSTART: cmd.div_start = 1'b1;
      S_DIV:    cmd.div_step  = 1'b1;
      S_CHECK:  cmd.finish    = sts.bad || sts.num_zero;
      S_OUT:    cmd.finish    = !out_valid_r;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE:   if (in_valid) state_r <= S_MUL;
        S_MUL:    state_r <= S_COMB;
        S_COMB:   state_r <= S_CHECK;
        S_CHECK: begin
          if (sts.bad || sts.num_zero) begin
            state_r     <= S_OUT;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= S_GCD;
          end
        end
        S_GCD:    if (sts.gcd_done) state_r <= S_DSTART;
        S_DSTART: state_r <= S_DIV;
        S_DIV:    if (sts.div_done) state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
          end else if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default:  state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rational_arith_unit.sv
`default_nettype none
// Rational arithmetic on two sign-magnitude fractions: add, subtract, multiply
// or divide by cross products, then reduction by the Euclidean gcd. One request
// is in flight at a time. A request passes through setup, then Euclid steps on
// a bit-serial remainder unit, then a bit-serial quotient pass; the number of
// Euclid steps depends on the operands. Zero denominators and divide by zero
// report status 1, reduced magnitudes wider than MAG_WIDTH report status 2.
module rational_arith_unit
  import rau_pkg::*;
#(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rau_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  rau_datapath #(.MAG_WIDTH(MAG_WIDTH)) u_dp (
    .clk, .rst_n, .req(in_data), .cmd, .sts, .res(out_data)
  );

endmodule
`default_nettype wire
